// ----- rtl/core/hltp_pkg.sv -----
// Shared types, character codes and keyword tables of the hash line token parser.
// Used by hltp_cmp, hltp_core and hash_line_token_parser_top; depends on nothing.
package hltp_pkg;

  // Item kind codes.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  // Character codes.
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_FIVE = 8'h35;

  // Keywords, first character in the most significant byte.
  localparam logic [71:0] KW_CONNECTED = "connected";
  localparam logic [55:0] KW_CONTROL   = "control";
  localparam logic [31:0] KW_WIFI      = "wifi";

  // Input item: one received byte or one poll.
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       part;
    logic       command_ok;
    logic       last;
    logic       network_up;
    logic       broker_connected;
    logic       line_seen;
  } res_item_t;

  // Line framing state.
  typedef enum logic [1:0] {
    P_WAIT  = 2'd0,
    P_TOKEN = 2'd1,
    P_PARAM = 2'd2
  } pstate_e;

  // Keyword candidate chosen by token length.
  typedef enum logic [1:0] {
    WORD_NONE      = 2'd0,
    WORD_CONNECTED = 2'd1,
    WORD_CONTROL   = 2'd2,
    WORD_WIFI      = 2'd3
  } word_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE      = 3'd0,
    S_REPLY     = 3'd1,
    S_MATCH_RD  = 3'd2,
    S_MATCH_CMP = 3'd3,
    S_COPY_RD   = 3'd4,
    S_COPY_WR   = 3'd5,
    S_EMIT_RD   = 3'd6,
    S_EMIT_OUT  = 3'd7
  } state_e;

  // Request to the shared byte comparator.
  typedef struct packed {
    logic [7:0] data;
    logic       use_plus;
    word_e      word;
    logic [3:0] idx;
  } cmp_req_t;

  // Index of the last character of a keyword.
  function automatic logic [3:0] word_last(input word_e w);
    logic [3:0] r;
    case (w)
      WORD_CONNECTED: r = 4'd8;
      WORD_CONTROL:   r = 4'd6;
      WORD_WIFI:      r = 4'd3;
      default:        r = 4'd0;
    endcase
    return r;
  endfunction

  // Character at position i of a keyword.
  function automatic logic [7:0] word_char(input word_e w, input logic [3:0] i);
    logic [71:0] s;
    logic [3:0]  sel;
    case (w)
      WORD_CONNECTED: s = KW_CONNECTED;
      WORD_CONTROL:   s = {16'h0000, KW_CONTROL};
      WORD_WIFI:      s = {40'h0000000000, KW_WIFI};
      default:        s = '0;
    endcase
    sel = word_last(w) - i;
    return s[{sel, 3'b000} +: 8];
  endfunction

endpackage

// ----- rtl/core/hltp_cmp.sv -----
// Shared byte comparator of the hash line token parser: checks a stored byte
// against a keyword character or the plus sign. Depends on hltp_pkg.
module hltp_cmp (
  input  hltp_pkg::cmp_req_t req_i,
  output logic               eq_o
);
  import hltp_pkg::*;

  logic [7:0] target;

  // Pick the reference character and compare.
  always_comb begin
    if (req_i.use_plus) begin
      target = CHAR_PLUS;
    end else begin
      target = word_char(req_i.word, req_i.idx);
    end
    eq_o = (req_i.data == target);
  end

endmodule

// ----- rtl/core/hltp_core.sv -----
// Sequencer, stores and flags of the hash line token parser. Frames lines,
// matches keywords and finds the plus through hltp_cmp, latches commands and
// plays them back. Depends on hltp_pkg and hltp_cmp.
module hltp_core #(
  parameter int TOKEN_DEPTH = 16,
  parameter int PARAM_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  hltp_pkg::in_item_t  in_item_i,
  output logic                in_ready_o,
  output logic                res_valid_o,
  output hltp_pkg::res_item_t res_item_o,
  input  logic                res_ready_i
);
  import hltp_pkg::*;

  localparam int TW = $clog2(TOKEN_DEPTH);
  localparam int PW = $clog2(PARAM_DEPTH);
  localparam int IW = (TW > PW) ? TW : PW;

  // Stores, undefined until written.
  logic [7:0] tok_mem [TOKEN_DEPTH];
  logic [7:0] prm_mem [PARAM_DEPTH];
  logic [7:0] cmd_mem [PARAM_DEPTH];
  logic [7:0] tok_rdata_q, prm_rdata_q, cmd_rdata_q;
  logic       tok_we, prm_we, cmd_we;

  state_e        state_q, state_d;
  pstate_e       pstate_q, pstate_d;
  word_e         word_q, word_d;
  logic [TW-1:0] tok_cnt_q, tok_cnt_d;
  logic [PW-1:0] prm_cnt_q, prm_cnt_d;
  logic [PW-1:0] cmd_cnt_q, cmd_cnt_d;
  logic [PW-1:0] plus_idx_q, plus_idx_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    prm_first_q, prm_first_d;
  logic          pend_q, pend_d;
  logic          plus_found_q, plus_found_d;
  logic          net_q, net_d;
  logic          brk_q, brk_d;
  logic          line_q, line_d;
  logic          ok_q, ok_d;

  cmp_req_t      cmp_req;
  logic          cmp_eq;
  logic [7:0]    c;
  logic          eol;
  logic [PW-1:0] pos;
  logic          last_item;
  word_e         cand;

  hltp_cmp u_cmp (
    .req_i (cmp_req),
    .eq_o  (cmp_eq)
  );

  // Memory write and registered read ports.
  always_ff @(posedge clk_i) begin
    if (tok_we) begin
      tok_mem[tok_cnt_q] <= c;
    end
    if (prm_we) begin
      prm_mem[prm_cnt_q] <= c;
    end
    if (cmd_we) begin
      cmd_mem[idx_q[PW-1:0]] <= prm_rdata_q;
    end
    tok_rdata_q <= tok_mem[idx_q[TW-1:0]];
    prm_rdata_q <= prm_mem[idx_q[PW-1:0]];
    cmd_rdata_q <= cmd_mem[idx_q[PW-1:0]];
  end

  // Control and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pstate_q     <= P_WAIT;
      word_q       <= WORD_NONE;
      tok_cnt_q    <= '0;
      prm_cnt_q    <= '0;
      cmd_cnt_q    <= '0;
      plus_idx_q   <= '0;
      idx_q        <= '0;
      prm_first_q  <= '0;
      pend_q       <= 1'b0;
      plus_found_q <= 1'b0;
      net_q        <= 1'b0;
      brk_q        <= 1'b0;
      line_q       <= 1'b0;
      ok_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      pstate_q     <= pstate_d;
      word_q       <= word_d;
      tok_cnt_q    <= tok_cnt_d;
      prm_cnt_q    <= prm_cnt_d;
      cmd_cnt_q    <= cmd_cnt_d;
      plus_idx_q   <= plus_idx_d;
      idx_q        <= idx_d;
      prm_first_q  <= prm_first_d;
      pend_q       <= pend_d;
      plus_found_q <= plus_found_d;
      net_q        <= net_d;
      brk_q        <= brk_d;
      line_q       <= line_d;
      ok_q         <= ok_d;
    end
  end

  // Input decode and keyword candidate from the token length.
  always_comb begin
    c   = in_item_i.rx_byte;
    eol = (c == CHAR_CR) || (c == CHAR_LF);
    pos = idx_q[PW-1:0];
    if (tok_cnt_q == TW'(9)) begin
      cand = WORD_CONNECTED;
    end else if (tok_cnt_q == TW'(7)) begin
      cand = WORD_CONTROL;
    end else if (tok_cnt_q == TW'(4)) begin
      cand = WORD_WIFI;
    end else begin
      cand = WORD_NONE;
    end
    last_item = (pos == cmd_cnt_q - PW'(1)) ||
                ((pos == cmd_cnt_q - PW'(2)) && (plus_idx_q == cmd_cnt_q - PW'(1)));
  end

  // Sequencer: next state and outputs.
  always_comb begin
    state_d      = state_q;
    pstate_d     = pstate_q;
    word_d       = word_q;
    tok_cnt_d    = tok_cnt_q;
    prm_cnt_d    = prm_cnt_q;
    cmd_cnt_d    = cmd_cnt_q;
    plus_idx_d   = plus_idx_q;
    idx_d        = idx_q;
    prm_first_d  = prm_first_q;
    pend_d       = pend_q;
    plus_found_d = plus_found_q;
    net_d        = net_q;
    brk_d        = brk_q;
    line_d       = line_q;
    ok_d         = ok_q;
    tok_we       = 1'b0;
    prm_we       = 1'b0;
    cmd_we       = 1'b0;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;

    res_item_o.data_byte        = '0;
    res_item_o.byte_valid       = 1'b0;
    res_item_o.part             = 1'b0;
    res_item_o.command_ok       = ok_q;
    res_item_o.last             = 1'b1;
    res_item_o.network_up       = net_q;
    res_item_o.broker_connected = brk_q;
    res_item_o.line_seen        = line_q;

    cmp_req.data     = prm_rdata_q;
    cmp_req.use_plus = 1'b1;
    cmp_req.word     = word_q;
    cmp_req.idx      = idx_q[3:0];

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d = '0;
          if (in_item_i.kind == KIND_BYTE) begin
            ok_d    = 1'b0;
            state_d = S_REPLY;
            case (pstate_q)
              P_TOKEN: begin
                if (c == CHAR_PLUS) begin
                  prm_cnt_d = '0;
                  pstate_d  = P_PARAM;
                end else if (eol) begin
                  prm_cnt_d = '0;
                  line_d    = 1'b1;
                  pstate_d  = P_WAIT;
                  word_d    = cand;
                  if (cand != WORD_NONE) begin
                    state_d = S_MATCH_RD;
                  end
                end else if (tok_cnt_q != TW'(TOKEN_DEPTH - 1)) begin
                  tok_we    = 1'b1;
                  tok_cnt_d = tok_cnt_q + TW'(1);
                end
              end
              P_PARAM: begin
                if (eol) begin
                  line_d   = 1'b1;
                  pstate_d = P_WAIT;
                  word_d   = cand;
                  if (cand != WORD_NONE) begin
                    state_d = S_MATCH_RD;
                  end
                end else if (prm_cnt_q != PW'(PARAM_DEPTH - 1)) begin
                  prm_we    = 1'b1;
                  prm_cnt_d = prm_cnt_q + PW'(1);
                  if (prm_cnt_q == '0) begin
                    prm_first_d = c;
                  end
                end
              end
              default: begin
                if (c == CHAR_HASH) begin
                  tok_cnt_d = '0;
                  pstate_d  = P_TOKEN;
                end else begin
                  pstate_d = P_WAIT;
                end
              end
            endcase
          end else begin
            // Poll: the latch is released whatever is found.
            pend_d = 1'b0;
            ok_d   = pend_q && plus_found_q;
            if (pend_q && plus_found_q && (cmd_cnt_q != PW'(1))) begin
              state_d = S_EMIT_RD;
            end else begin
              state_d = S_REPLY;
            end
          end
        end
      end

      S_REPLY: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          ok_d    = 1'b0;
          state_d = S_IDLE;
        end
      end

      S_MATCH_RD: begin
        state_d = S_MATCH_CMP;
      end

      // One token character against the keyword per pass.
      S_MATCH_CMP: begin
        cmp_req.data     = tok_rdata_q;
        cmp_req.use_plus = 1'b0;
        if (!cmp_eq) begin
          state_d = S_REPLY;
        end else if (idx_q == IW'(word_last(word_q))) begin
          state_d = S_REPLY;
          case (word_q)
            WORD_CONNECTED: brk_d = 1'b1;
            WORD_WIFI: begin
              if ((prm_cnt_q != '0) && (prm_first_q == CHAR_FIVE)) begin
                net_d = 1'b1;
              end
            end
            WORD_CONTROL: begin
              if (!pend_q) begin
                plus_found_d = 1'b0;
                idx_d        = '0;
                if (prm_cnt_q == '0) begin
                  cmd_cnt_d = '0;
                  pend_d    = 1'b1;
                end else begin
                  state_d = S_COPY_RD;
                end
              end
            end
            default: state_d = S_REPLY;
          endcase
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_MATCH_RD;
        end
      end

      S_COPY_RD: begin
        state_d = S_COPY_WR;
      end

      // Copy one param byte into the command store and note the first plus.
      S_COPY_WR: begin
        cmd_we = 1'b1;
        if (cmp_eq && !plus_found_q) begin
          plus_found_d = 1'b1;
          plus_idx_d   = pos;
        end
        if (pos == prm_cnt_q - PW'(1)) begin
          cmd_cnt_d = prm_cnt_q;
          pend_d    = 1'b1;
          state_d   = S_REPLY;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_COPY_RD;
        end
      end

      S_EMIT_RD: begin
        state_d = S_EMIT_OUT;
      end

      // Play back one command byte; the separating plus is skipped.
      S_EMIT_OUT: begin
        if (pos == plus_idx_q) begin
          idx_d   = idx_q + IW'(1);
          state_d = S_EMIT_RD;
        end else begin
          res_valid_o           = 1'b1;
          res_item_o.data_byte  = cmd_rdata_q;
          res_item_o.byte_valid = 1'b1;
          res_item_o.part       = (pos > plus_idx_q);
          res_item_o.command_ok = 1'b1;
          res_item_o.last       = last_item;
          if (res_ready_i) begin
            if (last_item) begin
              ok_d    = 1'b0;
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_q + IW'(1);
              state_d = S_EMIT_RD;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/hash_line_token_parser_top.sv -----
// Top level of the hash line token parser: input channel, sequencer core and
// output register. Depends on hltp_pkg and hltp_core.
//
// Usage: each input transfer carries either a received serial byte (kind 0)
// or a poll for the latched control command (kind 1). A received byte gives
// exactly one result with the sticky line, broker and network flags as they
// stand after that byte. A poll gives one result per command byte (actuator
// bytes, then value bytes, the separating plus dropped) or one item with no
// byte, failed unless the command is a lone plus; last marks each input's end.
// Flow: the block takes one input at a time. A byte that does not end a
// line goes straight to its result. An end of line compares the token with
// the keyword character by character, each through a read and a compare
// state, and, for a new control command, copies each param byte into the
// command store through a read and a write state. A poll that finds a
// command with a plus and another byte reads each stored byte but a final
// plus, and sends all but the plus; other polls go straight to their
// result. The shared comparator and one read port per store set these steps.
// Reset clears the framing state, counts, pending latch and flags; the byte
// stores need no clearing. A result waits in the output register while the
// receiver stalls, and the core holds the next result until it is taken.
module hash_line_token_parser_top #(
  parameter int TOKEN_DEPTH = 16,
  parameter int PARAM_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hltp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hltp_pkg::res_item_t out_item_o
);
  import hltp_pkg::*;

  logic      res_valid;
  logic      res_ready;
  res_item_t res_item;
  logic      out_valid_q, out_valid_d;
  res_item_t out_item_q;

  hltp_core #(
    .TOKEN_DEPTH (TOKEN_DEPTH),
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_ready_o  (in_ready_o),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .res_ready_i (res_ready)
  );

  // Output register: loads when empty or when its item is being taken.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // An accepted input takes the core out of its idle state and so stops it accepting further input.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("input accepted twice in a row");

  // A command byte is only ever sent on a successful poll.
  a_byte_needs_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.byte_valid |-> out_item_o.command_ok
  ) else $error("command byte without command_ok");

  // An item without a byte is a lone, final item with cleared data.
  a_empty_item: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.byte_valid |->
      out_item_o.last && !out_item_o.part && (out_item_o.data_byte == 8'h00)
  ) else $error("malformed item without command byte");

endmodule
